// ----- hw/rtl/gpd_pkg.sv -----
// Shared types, constants and helper functions for the gimbal pose point deskew core.
package gpd_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int AW         = $clog2(HIST_DEPTH);
  localparam int CW         = $clog2(HIST_DEPTH + 1);

  localparam int TIME_W   = 48;
  localparam int ANG_W    = 16;
  localparam int COORD_W  = 25;
  localparam int RATIO_W  = 17;
  localparam int LANG_W   = 18;
  localparam int TRIG_W   = 32;
  localparam int CXY_W    = 34;
  localparam int CZ_W     = 32;
  localparam int RCOORD_W = 28;
  localparam int WIDE_W   = 32;
  localparam int PROD_W   = RCOORD_W + TRIG_W;
  localparam int ACC_W    = PROD_W + 2;

  localparam int CORD_STEPS = 24;
  localparam int CSTEP_W    = 5;

  localparam logic signed [CXY_W-1:0] CORDIC_GAIN = CXY_W'(652032874);
  localparam logic signed [CZ_W-1:0]  PI_Q24      = CZ_W'(52707179);
  localparam logic signed [CZ_W-1:0]  HALF_PI_Q24 = CZ_W'(26353589);

  localparam logic signed [RCOORD_W-1:0] MOUNT_X     = RCOORD_W'(1180);
  localparam logic signed [RCOORD_W-1:0] MOUNT_Z     = RCOORD_W'(4719);
  localparam logic signed [WIDE_W-1:0]   PITCH_ARM_Z = WIDE_W'(4063);
  localparam logic signed [WIDE_W-1:0]   YAW_ARM_X   = WIDE_W'(11796);
  localparam logic signed [WIDE_W-1:0]   YAW_ARM_Z   = WIDE_W'(55706);
  localparam logic signed [WIDE_W-1:0]   COORD_LIMIT = WIDE_W'(13107200);

  localparam int S_DATA_W = 176;
  localparam int M_DATA_W = 144;

  typedef struct packed {
    logic [TIME_W-1:0]       time_us;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
  } sample_t;

  function automatic logic [23:0] atan_q24(input logic [CSTEP_W-1:0] i);
    logic [23:0] v;
    case (i)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= (AW+1)'(HIST_DEPTH)) ? s - (AW+1)'(HIST_DEPTH) : s;
    return r[AW-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > COORD_LIMIT) r = COORD_LIMIT;
    else if (v < -COORD_LIMIT) r = -COORD_LIMIT;
    else r = v;
    return r[COORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/gpd_hist.sv -----
// Gimbal sample ring: synchronous memory with append and indexed read.
module gpd_hist (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  gpd_pkg::sample_t     wr_data,
  input  logic                 rd_en,
  input  logic [gpd_pkg::AW-1:0] rd_idx,
  output gpd_pkg::sample_t     rd_data,
  output logic [gpd_pkg::CW-1:0] count
);
  import gpd_pkg::*;

  sample_t mem [HIST_DEPTH];
  logic [AW-1:0] oldest;
  logic          full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign full    = (count == CW'(HIST_DEPTH));
  assign wr_addr = full ? oldest : wrap_idx((AW+1)'(oldest) + (AW+1)'(count));
  assign rd_addr = wrap_idx((AW+1)'(oldest) + (AW+1)'(rd_idx));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (wr_en) begin
      if (full) begin
        oldest <= wrap_idx((AW+1)'(oldest) + (AW+1)'(1));
      end else begin
        count <= count + CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HIST_DEPTH)) else $error("sample count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> $stable(count) && $stable(oldest)) else $error("ring moved without append");
  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    !full |-> oldest == '0) else $error("oldest moved before ring filled");
`endif
endmodule

// ----- hw/rtl/gpd_div.sv -----
// Restoring divider for the Q1.16 interpolation ratio, one quotient bit per cycle.
module gpd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gpd_pkg::TIME_W-1:0] dividend,
  input  logic [gpd_pkg::TIME_W-1:0] divisor,
  output logic                       done,
  output logic [gpd_pkg::RATIO_W-1:0] quo
);
  import gpd_pkg::*;

  logic [TIME_W-1:0] rem;
  logic [CSTEP_W-1:0] step;
  logic               busy;
  logic [TIME_W:0]    rem_sh;
  logic [TIME_W:0]    rem_sub;
  logic               ge;

  assign rem_sh  = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= dividend;
        quo  <= '0;
      end else if (busy) begin
        rem  <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        quo  <= {quo[RATIO_W-2:0], ge};
        step <= step + CSTEP_W'(1);
        if (step == CSTEP_W'(RATIO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("divider restarted while busy");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> step < CSTEP_W'(RATIO_W)) else $error("divider step overrun");
`endif
endmodule

// ----- hw/rtl/gpd_cordic.sv -----
// Iterative rotation-mode CORDIC: Q5.13 angle to Q2.30 cosine and sine.
module gpd_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [gpd_pkg::LANG_W-1:0] angle,
  output logic                              done,
  output logic signed [gpd_pkg::TRIG_W-1:0] cos_o,
  output logic signed [gpd_pkg::TRIG_W-1:0] sin_o
);
  import gpd_pkg::*;

  logic signed [CXY_W-1:0] x, y;
  logic signed [CZ_W-1:0]  z;
  logic                    flip;
  logic                    busy;
  logic [CSTEP_W-1:0]      step;
  logic signed [CZ_W-1:0]  z0;
  logic signed [CXY_W-1:0] xs, ys;
  logic signed [CZ_W-1:0]  at;
  logic signed [CXY_W-1:0] xn, yn;

  assign z0 = CZ_W'(angle) <<< 11;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = CZ_W'(atan_q24(step));
  assign xn = flip ? -x : x;
  assign yn = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        if (z0 > HALF_PI_Q24) begin
          z    <= z0 - PI_Q24;
          flip <= 1'b1;
        end else if (z0 < -HALF_PI_Q24) begin
          z    <= z0 + PI_Q24;
          flip <= 1'b1;
        end else begin
          z    <= z0;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        step <= step + CSTEP_W'(1);
        if (step == CSTEP_W'(CORD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_o = xn[TRIG_W-1:0];
  assign sin_o = yn[TRIG_W-1:0];

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("cordic done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("cordic restarted while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(x) && $stable(y)) else $error("cordic result drifted");
`endif
endmodule

// ----- hw/rtl/gimbal_pose_point_deskew_core.sv -----
// Top level: sample ring lookup, ratio, angle interpolation, sin/cos and point transform.
// Sample transaction: written to the ring, no result.
// Point transaction: ring scan to match index k, divider, interpolation, the shared CORDIC
//   twice (yaw, then pitch), eight products on one multiplier, then the result is emitted.
// One item at a time; a waiting result does not block the next item from starting.
// Synchronous reset empties the ring and drops any item in flight; stored samples are not cleared.
module gimbal_pose_point_deskew_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // time_us[47:0], yaw_angle[63:48], pitch_angle[79:64], px[104:80], py[129:105],
  // pz[154:130], intensity[162:155], ring[170:163], zero[175:171]
  input  logic [175:0] s_tdata,
  // func[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // wx[24:0], wy[49:25], wz[74:50], out_intensity[82:75], out_ring[90:83],
  // out_time_us[138:91], zero[143:139]
  output logic [143:0] m_tdata
);
  import gpd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIV, ST_LERP, ST_TRIG_Y, ST_TRIG_P, ST_ROT, ST_EMIT
  } state_t;

  localparam logic FUNC_SAMPLE = 1'b0;

  state_t state;

  logic [TIME_W-1:0]          pt_time;
  logic signed [COORD_W-1:0]  pt_x, pt_y, pt_z;
  logic [7:0]                 pt_int, pt_ring;

  sample_t                    wr_sample;
  logic                       wr_en;
  logic                       rd_en;
  sample_t                    rd_data;
  logic [CW-1:0]              count;
  logic [CW-1:0]              iss_k, cmp_k;
  logic                       rd_vld;
  sample_t                    prev, cur;

  logic                       div_start, div_done;
  logic [RATIO_W-1:0]         ratio;

  logic signed [LANG_W-1:0]   yaw_ang, pitch_ang;
  logic                       cdc_start, cdc_done;
  logic signed [TRIG_W-1:0]   cdc_cos, cdc_sin;
  logic signed [TRIG_W-1:0]   cy, sy, cp, sp;

  logic signed [ANG_W:0]      dyaw, dpitch;
  logic signed [34:0]         yprod, pprod;
  logic signed [LANG_W-1:0]   yaw_lerp, pitch_lerp;

  logic [2:0]                 rstep;
  logic                       rphase;
  logic signed [RCOORD_W-1:0] qx, qy, qz, rx, rz;
  logic signed [RCOORD_W-1:0] op_a;
  logic signed [TRIG_W-1:0]   op_b;
  logic                       op_neg;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc, acc_sum;
  logic signed [WIDE_W-1:0]   rnd;
  logic signed [WIDE_W-1:0]   wx_r, wy_r;

  assign s_tready = (state == ST_IDLE);
  assign wr_en    = s_tvalid && s_tready && (s_tuser == FUNC_SAMPLE);
  assign wr_sample.time_us = s_tdata[47:0];
  assign wr_sample.yaw     = s_tdata[63:48];
  assign wr_sample.pitch   = s_tdata[79:64];
  assign rd_en    = (state == ST_SCAN) && (iss_k < count);

  gpd_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_sample),
    .rd_en   (rd_en),
    .rd_idx  (iss_k[AW-1:0]),
    .rd_data (rd_data),
    .count   (count)
  );

  gpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pt_time - prev.time_us),
    .divisor  (cur.time_us - prev.time_us),
    .done     (div_done),
    .quo      (ratio)
  );

  gpd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cdc_start),
    .angle ((state == ST_TRIG_P) ? pitch_ang : yaw_ang),
    .done  (cdc_done),
    .cos_o (cdc_cos),
    .sin_o (cdc_sin)
  );

  assign dyaw       = (ANG_W+1)'(cur.yaw) - (ANG_W+1)'(prev.yaw);
  assign dpitch     = (ANG_W+1)'(cur.pitch) - (ANG_W+1)'(prev.pitch);
  assign yprod      = 35'(dyaw) * 35'($signed({1'b0, ratio})) + 35'sd32768;
  assign pprod      = 35'(dpitch) * 35'($signed({1'b0, ratio})) + 35'sd32768;
  assign yaw_lerp   = LANG_W'(prev.yaw) + LANG_W'(yprod[34:16]);
  assign pitch_lerp = LANG_W'(prev.pitch) + LANG_W'(pprod[34:16]);

  assign qx = RCOORD_W'(pt_x) + MOUNT_X;
  assign qy = RCOORD_W'(pt_y);
  assign qz = RCOORD_W'(pt_z) + MOUNT_Z;

  always_comb begin
    op_a   = qx;
    op_b   = cp;
    op_neg = 1'b0;
    case (rstep)
      3'd0: begin op_a = qx; op_b = cp; end
      3'd1: begin op_a = qz; op_b = sp; end
      3'd2: begin op_a = qz; op_b = cp; end
      3'd3: begin op_a = qx; op_b = sp; op_neg = 1'b1; end
      3'd4: begin op_a = rx; op_b = cy; end
      3'd5: begin op_a = qy; op_b = sy; op_neg = 1'b1; end
      3'd6: begin op_a = rx; op_b = sy; end
      default: begin op_a = qy; op_b = cy; end
    endcase
  end

  assign acc_sum = (rstep[0] ? acc : ACC_W'(0)) + (op_neg ? -ACC_W'(prod) : ACC_W'(prod));
  assign rnd     = WIDE_W'((acc_sum + ACC_W'(64'sd536870912)) >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
      cdc_start <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld    <= rd_en;
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          iss_k <= '0;
          if (s_tvalid && s_tuser != FUNC_SAMPLE) begin
            pt_time <= s_tdata[47:0];
            pt_x    <= s_tdata[104:80];
            pt_y    <= s_tdata[129:105];
            pt_z    <= s_tdata[154:130];
            pt_int  <= s_tdata[162:155];
            pt_ring <= s_tdata[170:163];
            if (count >= CW'(2)) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            iss_k <= iss_k + CW'(1);
          end
          cmp_k <= iss_k;
          if (rd_vld) begin
            if (rd_data.time_us >= pt_time) begin
              if (cmp_k == '0 || rd_data.time_us <= prev.time_us) begin
                state <= ST_IDLE;
              end else begin
                cur       <= rd_data;
                div_start <= 1'b1;
                state     <= ST_DIV;
              end
            end else begin
              prev <= rd_data;
              if (cmp_k + CW'(1) == count) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            state <= ST_LERP;
          end
        end
        ST_LERP: begin
          yaw_ang   <= yaw_lerp;
          pitch_ang <= pitch_lerp;
          cdc_start <= 1'b1;
          state     <= ST_TRIG_Y;
        end
        ST_TRIG_Y: begin
          cdc_start <= cdc_done;
          if (cdc_done) begin
            cy        <= cdc_cos;
            sy        <= cdc_sin;
            state     <= ST_TRIG_P;
          end
        end
        ST_TRIG_P: begin
          cdc_start <= 1'b0;
          if (cdc_done) begin
            cp     <= cdc_cos;
            sp     <= cdc_sin;
            rstep  <= '0;
            rphase <= 1'b0;
            state  <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (!rphase) begin
            prod   <= PROD_W'(op_a) * PROD_W'(op_b);
            rphase <= 1'b1;
          end else begin
            acc    <= acc_sum;
            rphase <= 1'b0;
            rstep  <= rstep + 3'd1;
            case (rstep)
              3'd1: rx   <= RCOORD_W'(rnd);
              3'd3: rz   <= RCOORD_W'(rnd + PITCH_ARM_Z);
              3'd5: wx_r <= rnd + YAW_ARM_X;
              3'd7: wy_r <= rnd;
              default: ;
            endcase
            if (rstep == 3'd7) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, pt_time, pt_ring, pt_int,
                         sat_coord(WIDE_W'(rz) + YAW_ARM_Z),
                         sat_coord(wy_r), sat_coord(wx_r)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EMIT)) else $error("result not from emit");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider finished outside ratio step");
  a_cordic_owner: assert property (@(posedge clk) disable iff (rst)
    cdc_done |-> (state == ST_TRIG_Y || state == ST_TRIG_P))
    else $error("cordic finished outside angle steps");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> iss_k <= count) else $error("scan past ring fill");
`endif
endmodule
